// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

    localparam int TICK_W  = 16;
    localparam int PHASE_W = 3;
    localparam int BIT_W   = 4;

    localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [BIT_W-1:0]  BITS_PER_BYTE     = 4'd8;

    // Command codes on the input word.
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_ADDR_WR  = 3'd5;
    localparam logic [2:0] CMD_ADDR_RD  = 3'd6;

    // Sequencer operation codes.
    localparam logic [2:0] OP_IDLE     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_START_WR = 3'd2;
    localparam logic [2:0] OP_STOP     = 3'd3;
    localparam logic [2:0] OP_WRITE    = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       nack_seen;
        logic [7:0] rx_byte;
    } t_result;

endpackage

// ===== rtl/i2cm_if.sv =====
// Handshake channel interfaces for configuration, commands and results.
interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_period_ticks;

    modport source (output valid, output half_period_ticks, input ready);
    modport sink   (input valid, input half_period_ticks, output ready);
endinterface

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic [6:0] target_address;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, output cmd, output tx_byte, output target_address,
                    output send_ack, output sda_in, input ready);
    modport sink   (input valid, input cmd, input tx_byte, input target_address,
                    input send_ack, input sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] rx_byte;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output nack_seen, output rx_byte, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input nack_seen, input rx_byte, output ready);
endinterface

// ===== rtl/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: channels, configuration and result register.
//
// Usage: every word on i_in is one system tick. It carries a command (start, stop,
// write byte, read byte, or start plus a 7-bit address with the R/W bit), the byte to
// send, the address, the ACK choice for reads and the sampled SDA level. A command is
// taken only while the engine is idle; words carrying a command while busy are ticks.
// Every accepted word yields exactly one result word on o_out with the SCL and SDA
// drive levels, busy, a one-tick done pulse, the last NACK bit and the last read byte.
// Each bus phase lasts half_period_ticks words, written through i_cfg (reset 100,
// zero acts as one); the channel is always ready and should be written while idle.
// The result for a word is registered and appears in the cycle after it is accepted.
// Throughput: one word per cycle while o_out takes results; the whole tick update is a single
// pass through the sequencer logic into the result register, so nothing else limits the rate.
// When o_out stalls, the held result keeps i_in ready low until it is taken, so no
// word is lost or repeated. Reset (synchronous, active low) releases both lines,
// returns the sequencer to idle, clears the flags and restores the half period.
module i2c_master_byte_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_cfg_if.sink    i_cfg,
    i2cm_in_if.sink     i_in,
    i2cm_out_if.source  o_out
);

    logic [i2cm_pkg::TICK_W-1:0] r_half_period;
    logic                        r_out_valid;
    logic                        n_out_valid;
    i2cm_pkg::t_result           r_result;
    i2cm_pkg::t_result           w_result;
    logic                        w_accept;

    // Configuration is a plain register write, always accepted.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cm_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg.valid) begin
            r_half_period <= i_cfg.half_period_ticks;
        end
    end

    // A new word can enter whenever the result register is empty or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    i2cm_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_accept),
        .i_cmd            (i_in.cmd),
        .i_tx_byte        (i_in.tx_byte),
        .i_target_address (i_in.target_address),
        .i_send_ack       (i_in.send_ack),
        .i_sda_in         (i_in.sda_in),
        .i_half_period    (r_half_period),
        .o_result         (w_result)
    );

    assign n_out_valid = w_accept || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // The result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl_out   = r_result.scl_out;
    assign o_out.sda_out   = r_result.sda_out;
    assign o_out.busy_res  = r_result.busy_res;
    assign o_out.done_res  = r_result.done_res;
    assign o_out.nack_seen = r_result.nack_seen;
    assign o_out.rx_byte   = r_result.rx_byte;

endmodule

// ===== rtl/i2cm_seq.sv =====
// Phase sequencer: bus state registers and the one-tick next-state logic.
module i2cm_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [2:0]                     i_cmd,
    input  logic [7:0]                     i_tx_byte,
    input  logic [6:0]                     i_target_address,
    input  logic                           i_send_ack,
    input  logic                           i_sda_in,
    input  logic [i2cm_pkg::TICK_W-1:0]    i_half_period,
    output i2cm_pkg::t_result              o_result
);

    typedef struct packed {
        logic [2:0]                     op;
        logic [i2cm_pkg::PHASE_W-1:0]   ps;
        logic [i2cm_pkg::BIT_W-1:0]     bc;
        logic [7:0]                     sh;
        logic [i2cm_pkg::TICK_W-1:0]    td;
        logic                           scl;
        logic                           sda;
        logic                           ack;
        logic                           nack;
        logic [7:0]                     rx;
    } t_seq_state;

    t_seq_state r_state;
    t_seq_state n_state;

    // Pin actions taken on entry to a phase.
    function automatic t_seq_state enter_phase(input t_seq_state s_in);
        t_seq_state s;
        s = s_in;
        unique case (s.op)
            i2cm_pkg::OP_START, i2cm_pkg::OP_START_WR: begin
                if (s.ps == '0) begin
                    s.sda = 1'b1;
                    s.scl = 1'b1;
                end else begin
                    s.sda = 1'b0;
                end
            end
            i2cm_pkg::OP_STOP: begin
                if (s.ps == 3'd0) s.sda = 1'b0;
                else if (s.ps == 3'd1) s.scl = 1'b1;
                else s.sda = 1'b1;
            end
            i2cm_pkg::OP_WRITE: begin
                unique case (s.ps)
                    3'd0: s.scl = 1'b0;
                    3'd1: begin
                        s.sda = s.sh[7];
                        s.sh  = {s.sh[6:0], 1'b0};
                    end
                    3'd2: s.scl = 1'b1;
                    3'd3: s.scl = 1'b0;
                    3'd4: s.sda = 1'b1;
                    default: s.scl = 1'b1;
                endcase
            end
            i2cm_pkg::OP_READ: begin
                if (s.ps == 3'd0) begin
                    s.sda = 1'b1;
                    s.scl = 1'b1;
                end else if (s.ps == 3'd1) begin
                    s.scl = 1'b0;
                end else begin
                    s.sda = ~s.ack;
                    s.scl = 1'b1;
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    logic                        w_done;
    logic                        w_taken;
    logic                        w_fin;
    logic [i2cm_pkg::TICK_W-1:0] w_hp;

    always_comb begin
        n_state = r_state;
        w_done  = 1'b0;
        w_taken = 1'b0;
        w_fin   = 1'b0;
        w_hp    = (i_half_period == '0) ? {{(i2cm_pkg::TICK_W-1){1'b0}}, 1'b1}
                                        : i_half_period;

        // Command acceptance while idle.
        if (n_state.op == i2cm_pkg::OP_IDLE) begin
            w_taken = 1'b1;
            unique case (i_cmd)
                i2cm_pkg::CMD_START: n_state.op = i2cm_pkg::OP_START;
                i2cm_pkg::CMD_STOP:  n_state.op = i2cm_pkg::OP_STOP;
                i2cm_pkg::CMD_WRITE: begin
                    n_state.op = i2cm_pkg::OP_WRITE;
                    n_state.sh = i_tx_byte;
                end
                i2cm_pkg::CMD_READ: begin
                    n_state.op  = i2cm_pkg::OP_READ;
                    n_state.sh  = '0;
                    n_state.ack = i_send_ack;
                end
                i2cm_pkg::CMD_ADDR_WR: begin
                    n_state.op = i2cm_pkg::OP_START_WR;
                    n_state.sh = {i_target_address, 1'b0};
                end
                i2cm_pkg::CMD_ADDR_RD: begin
                    n_state.op = i2cm_pkg::OP_START_WR;
                    n_state.sh = {i_target_address, 1'b1};
                end
                default: w_taken = 1'b0;
            endcase
            if (w_taken) begin
                n_state.ps = '0;
                n_state.bc = '0;
                n_state.td = '0;
                n_state    = enter_phase(n_state);
            end
        end

        // Half-period divider and end-of-phase actions.
        if (n_state.op != i2cm_pkg::OP_IDLE) begin
            n_state.td = n_state.td + 1'b1;
            if (n_state.td >= w_hp) begin
                n_state.td = '0;
                unique case (n_state.op)
                    i2cm_pkg::OP_START: begin
                        if (n_state.ps == '0) n_state.ps = 3'd1;
                        else w_fin = 1'b1;
                    end
                    i2cm_pkg::OP_START_WR: begin
                        if (n_state.ps == '0) begin
                            n_state.ps = 3'd1;
                        end else begin
                            n_state.op = i2cm_pkg::OP_WRITE;
                            n_state.ps = '0;
                            n_state.bc = '0;
                        end
                    end
                    i2cm_pkg::OP_STOP: begin
                        if (n_state.ps < 3'd2) n_state.ps = n_state.ps + 1'b1;
                        else w_fin = 1'b1;
                    end
                    i2cm_pkg::OP_WRITE: begin
                        if (n_state.ps == 3'd3) begin
                            n_state.bc = n_state.bc + 1'b1;
                            n_state.ps = (n_state.bc < i2cm_pkg::BITS_PER_BYTE) ? 3'd1 : 3'd4;
                        end else if (n_state.ps < 3'd5) begin
                            n_state.ps = n_state.ps + 1'b1;
                        end else begin
                            n_state.nack = i_sda_in;
                            n_state.scl  = 1'b0;
                            w_fin        = 1'b1;
                        end
                    end
                    i2cm_pkg::OP_READ: begin
                        if (n_state.ps == 3'd0) begin
                            n_state.sh = {n_state.sh[6:0], i_sda_in};
                            n_state.ps = 3'd1;
                        end else if (n_state.ps == 3'd1) begin
                            n_state.bc = n_state.bc + 1'b1;
                            n_state.ps = (n_state.bc < i2cm_pkg::BITS_PER_BYTE) ? 3'd0 : 3'd2;
                        end else begin
                            n_state.rx  = n_state.sh;
                            n_state.scl = 1'b0;
                            n_state.sda = 1'b1;
                            w_fin       = 1'b1;
                        end
                    end
                    default: w_fin = 1'b1;
                endcase
                if (w_fin) begin
                    n_state.op = i2cm_pkg::OP_IDLE;
                    n_state.ps = '0;
                    n_state.bc = '0;
                    w_done     = 1'b1;
                end else begin
                    n_state = enter_phase(n_state);
                end
            end
        end

        o_result.scl_out   = n_state.scl;
        o_result.sda_out   = n_state.sda;
        o_result.busy_res  = (n_state.op != i2cm_pkg::OP_IDLE);
        o_result.done_res  = w_done;
        o_result.nack_seen = n_state.nack;
        o_result.rx_byte   = n_state.rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.op   <= i2cm_pkg::OP_IDLE;
            r_state.ps   <= '0;
            r_state.bc   <= '0;
            r_state.sh   <= '0;
            r_state.td   <= '0;
            r_state.scl  <= 1'b1;
            r_state.sda  <= 1'b1;
            r_state.ack  <= 1'b0;
            r_state.nack <= 1'b0;
            r_state.rx   <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== tb/i2cm_bus_checker.sv =====
// Checker for the I2C master byte engine: predicts every result word and compares it.
`timescale 1ns / 1ps

module i2cm_bus_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2cm_cfg_if       i_cfg,
    i2cm_in_if        i_in,
    i2cm_out_if       i_result,
    output int        o_fail_count,
    output int        o_pending
);

    // Own copy of the sequencer state and of the half-period register.
    logic [i2cm_pkg::TICK_W-1:0] half_period;
    logic [2:0]                  op;
    logic [4:0]                  step;
    logic [i2cm_pkg::BIT_W-1:0]  bits_done;
    logic [7:0]                  shifter;
    logic [i2cm_pkg::TICK_W-1:0] divider;
    logic                        scl_q;
    logic                        sda_q;
    logic                        ack_q;
    logic                        nack_q;
    logic [7:0]                  rx_q;

    i2cm_pkg::t_result expected_words[$];
    int                mismatches;
    int                pending_words;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_words;

    // Pin levels set on entry to the current phase.
    function automatic void drive_phase_pins();
        unique case (op)
            i2cm_pkg::OP_START, i2cm_pkg::OP_START_WR: begin
                if (step == 0) begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end else begin
                    sda_q = 1'b0;
                end
            end
            i2cm_pkg::OP_STOP: begin
                if (step == 0)      sda_q = 1'b0;
                else if (step == 1) scl_q = 1'b1;
                else                sda_q = 1'b1;
            end
            i2cm_pkg::OP_WRITE: begin
                unique case (step)
                    5'd0: scl_q = 1'b0;
                    5'd1: begin
                        sda_q   = shifter[7];
                        shifter = {shifter[6:0], 1'b0};
                    end
                    5'd2: scl_q = 1'b1;
                    5'd3: scl_q = 1'b0;
                    5'd4: sda_q = 1'b1;
                    default: scl_q = 1'b1;
                endcase
            end
            i2cm_pkg::OP_READ: begin
                if (step == 0) begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end else if (step == 1) begin
                    scl_q = 1'b0;
                end else begin
                    sda_q = ~ack_q;
                    scl_q = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // One system tick of the sequencer; returns the result word it produces.
    task automatic predict_tick(input logic [2:0] cmd, input logic [7:0] tx,
                                input logic [6:0] addr, input logic ack,
                                input logic sda, output i2cm_pkg::t_result word);
        logic                        taken;
        logic                        finished;
        logic                        done;
        logic [i2cm_pkg::TICK_W-1:0] limit;
        taken    = 1'b1;
        finished = 1'b0;
        done     = 1'b0;
        if (op == i2cm_pkg::OP_IDLE) begin
            unique case (cmd)
                i2cm_pkg::CMD_START: op = i2cm_pkg::OP_START;
                i2cm_pkg::CMD_STOP:  op = i2cm_pkg::OP_STOP;
                i2cm_pkg::CMD_WRITE: begin
                    op      = i2cm_pkg::OP_WRITE;
                    shifter = tx;
                end
                i2cm_pkg::CMD_READ: begin
                    op      = i2cm_pkg::OP_READ;
                    shifter = 8'h00;
                    ack_q   = ack;
                end
                i2cm_pkg::CMD_ADDR_WR: begin
                    op      = i2cm_pkg::OP_START_WR;
                    shifter = {addr, 1'b0};
                end
                i2cm_pkg::CMD_ADDR_RD: begin
                    op      = i2cm_pkg::OP_START_WR;
                    shifter = {addr, 1'b1};
                end
                default: taken = 1'b0;
            endcase
            if (taken) begin
                step      = 5'd0;
                bits_done = '0;
                divider   = '0;
                drive_phase_pins();
            end
        end
        if (op != i2cm_pkg::OP_IDLE) begin
            limit   = (half_period == '0) ? 16'd1 : half_period;
            divider = divider + 1'b1;
            if (divider >= limit) begin
                divider = '0;
                unique case (op)
                    i2cm_pkg::OP_START: begin
                        if (step == 0) step = 5'd1;
                        else           finished = 1'b1;
                    end
                    i2cm_pkg::OP_START_WR: begin
                        if (step == 0) begin
                            step = 5'd1;
                        end else begin
                            op        = i2cm_pkg::OP_WRITE;
                            step      = 5'd0;
                            bits_done = '0;
                        end
                    end
                    i2cm_pkg::OP_STOP: begin
                        if (step < 2) step = step + 1'b1;
                        else          finished = 1'b1;
                    end
                    i2cm_pkg::OP_WRITE: begin
                        if (step == 3) begin
                            bits_done = bits_done + 1'b1;
                            step = (bits_done < i2cm_pkg::BITS_PER_BYTE) ? 5'd1 : 5'd4;
                        end else if (step < 5) begin
                            step = step + 1'b1;
                        end else begin
                            // The ACK bit is sampled as the last phase closes.
                            nack_q   = sda;
                            scl_q    = 1'b0;
                            finished = 1'b1;
                        end
                    end
                    i2cm_pkg::OP_READ: begin
                        if (step == 0) begin
                            shifter = {shifter[6:0], sda};
                            step    = 5'd1;
                        end else if (step == 1) begin
                            bits_done = bits_done + 1'b1;
                            step = (bits_done < i2cm_pkg::BITS_PER_BYTE) ? 5'd0 : 5'd2;
                        end else begin
                            rx_q     = shifter;
                            scl_q    = 1'b0;
                            sda_q    = 1'b1;
                            finished = 1'b1;
                        end
                    end
                    default: finished = 1'b1;
                endcase
                if (finished) begin
                    op        = i2cm_pkg::OP_IDLE;
                    step      = 5'd0;
                    bits_done = '0;
                    done      = 1'b1;
                end else begin
                    drive_phase_pins();
                end
            end
        end
        word.scl_out   = scl_q;
        word.sda_out   = sda_q;
        word.busy_res  = (op != i2cm_pkg::OP_IDLE);
        word.done_res  = done;
        word.nack_seen = nack_q;
        word.rx_byte   = rx_q;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        mismatches    = 0;
        pending_words = 0;
    end

    always @(posedge i_clk) begin
        i2cm_pkg::t_result want;
        i2cm_pkg::t_result next_word;
        if (!i_rst_n) begin
            half_period = i2cm_pkg::HALF_PERIOD_RESET;
            op          = i2cm_pkg::OP_IDLE;
            step        = 5'd0;
            bits_done   = '0;
            shifter     = 8'h00;
            divider     = '0;
            scl_q       = 1'b1;
            sda_q       = 1'b1;
            ack_q       = 1'b0;
            nack_q      = 1'b0;
            rx_q        = 8'h00;
            expected_words.delete();
        end else begin
            // A result accepted now belongs to an earlier word, so compare first.
            if (i_result.valid && i_result.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %0h", $time,
                             {i_result.scl_out, i_result.sda_out, i_result.busy_res,
                              i_result.done_res, i_result.nack_seen, i_result.rx_byte});
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("scl_out", want.scl_out, i_result.scl_out);
                    check_field("sda_out", want.sda_out, i_result.sda_out);
                    check_field("busy_res", want.busy_res, i_result.busy_res);
                    check_field("done_res", want.done_res, i_result.done_res);
                    check_field("nack_seen", want.nack_seen, i_result.nack_seen);
                    check_field("rx_byte", want.rx_byte, i_result.rx_byte);
                end
            end
            // A word taken at the same edge as a write still sees the old half period.
            if (i_in.valid && i_in.ready) begin
                predict_tick(i_in.cmd, i_in.tx_byte, i_in.target_address, i_in.send_ack,
                             i_in.sda_in, next_word);
                expected_words.push_back(next_word);
            end
            if (i_cfg.valid && i_cfg.ready) half_period = i_cfg.half_period_ticks;
        end
        pending_words <= expected_words.size();
    end

endmodule

// ===== tb/tb_i2c_master_byte_engine.sv =====
// Testbench top for the I2C master byte engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;

    // Code seven is not a command; the engine must treat it like none.
    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         TAIL_CYCLES = 8;
    localparam int         PHASE_WORDS = 120;

    logic i_clk;
    logic i_rst_n;

    i2cm_cfg_if cfg_ch ();
    i2cm_in_if  in_ch ();
    i2cm_out_if out_ch ();

    int  fail_count;
    int  pending;
    int  cycle_count;
    int  words_sent;
    int  done_count;
    int  settings_used;
    bit  gaps_on;
    // Busy flag of the most recent result word taken from the engine.
    logic last_busy;

    i2c_master_byte_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    i2cm_bus_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // The stimulus follows the engine's busy flag from the result words it sees.
    // It lags by a word or two, which is fine: a command sent too early is simply
    // ignored by the engine and the checker predicts exactly that.
    initial begin
        last_busy  = 1'b0;
        done_count = 0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            last_busy <= out_ch.busy_res;
            if (out_ch.done_res) done_count <= done_count + 1;
        end
    end

    // The result sink stalls about one cycle in three while gaps are enabled.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= gaps_on ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // Sends one tick word and returns at the edge where the engine takes it.
    // Source gaps are inserted before the word, never between valid and ready.
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] tx,
                             input logic [6:0] addr, input logic ack, input logic sda);
        while (gaps_on && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= cmd;
        in_ch.tx_byte        <= tx;
        in_ch.target_address <= addr;
        in_ch.send_ack       <= ack;
        in_ch.sda_in         <= sda;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Drops valid and waits until every word sent so far has come back. The edge
    // is taken first so that the count already includes the last accepted word.
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Ticks the engine with no command until it reports idle and nothing is in flight.
    task automatic run_until_idle(input logic sda);
        do begin
            while (last_busy) begin
                send_word(i2cm_pkg::CMD_NONE, 8'($urandom), 7'($urandom), 1'($urandom),
                          sda);
            end
            wait_results();
        end while (last_busy);
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [7:0] tx,
                         input logic [6:0] addr, input logic ack, input logic sda);
        send_word(cmd, tx, addr, ack, sda);
        run_until_idle(sda);
    endtask

    // The engine is idle here, so the new half period takes effect cleanly.
    task automatic write_half_period(input logic [15:0] value);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.half_period_ticks <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Random tick words. When the engine looks idle a new command is likely; while
    // it is busy most words are plain ticks and a few carry commands that must be
    // ignored. The sampled SDA level is random on every tick, so ACK bits and read
    // data come out random.
    task automatic random_ticks(input int count);
        logic [2:0] cmd;
        int         pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if (!last_busy) begin
                if (pick == 0)      cmd = i2cm_pkg::CMD_NONE;
                else if (pick == 1) cmd = CMD_UNUSED;
                else cmd = 3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_ADDR_RD));
            end else begin
                cmd = (pick < 2) ? 3'($urandom_range(0, 7)) : i2cm_pkg::CMD_NONE;
            end
            send_word(cmd, 8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        logic [15:0] phase_setting [5];
        i_rst_n                  <= 1'b0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.half_period_ticks <= i2cm_pkg::HALF_PERIOD_RESET;
        in_ch.valid              <= 1'b0;
        in_ch.cmd                <= i2cm_pkg::CMD_NONE;
        in_ch.tx_byte            <= 8'h00;
        in_ch.target_address     <= 7'h00;
        in_ch.send_ack           <= 1'b0;
        in_ch.sda_in             <= 1'b1;
        gaps_on       = 1'b1;
        words_sent    = 0;
        settings_used = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A start condition at the reset half period checks that default.
        issue(i2cm_pkg::CMD_START, 8'h00, 7'h00, 1'b0, 1'b1);

        // Directed commands at the shortest phase length.
        write_half_period(16'd1);
        // With one tick per phase the start finishes on its second tick; the write
        // offered on that done tick must be dropped and the next one taken.
        send_word(i2cm_pkg::CMD_START, 8'h00, 7'h00, 1'b0, 1'b0);
        send_word(i2cm_pkg::CMD_WRITE, 8'h5A, 7'h00, 1'b0, 1'b0);
        send_word(i2cm_pkg::CMD_WRITE, 8'hA5, 7'h00, 1'b0, 1'b0);
        // A command arriving mid-transfer is ignored as well.
        send_word(i2cm_pkg::CMD_READ, 8'h00, 7'h00, 1'b1, 1'b0);
        run_until_idle(1'b0);
        issue(i2cm_pkg::CMD_ADDR_WR, 8'h00, 7'h7F, 1'b0, 1'b0);
        issue(i2cm_pkg::CMD_ADDR_RD, 8'hFF, 7'h00, 1'b1, 1'b1);
        // All-ones with a NACK and all-zeros with an ACK.
        issue(i2cm_pkg::CMD_WRITE, 8'hFF, 7'h00, 1'b0, 1'b1);
        issue(i2cm_pkg::CMD_WRITE, 8'h00, 7'h7F, 1'b1, 1'b0);
        // Reads of all ones ending in ACK and all zeros ending in NACK.
        issue(i2cm_pkg::CMD_READ, 8'h00, 7'h00, 1'b1, 1'b1);
        issue(i2cm_pkg::CMD_READ, 8'hFF, 7'h7F, 1'b0, 1'b0);
        issue(i2cm_pkg::CMD_STOP, 8'h00, 7'h00, 1'b0, 1'b1);
        // Neither none nor the unused code may start anything.
        send_word(CMD_UNUSED, 8'hFF, 7'h7F, 1'b1, 1'b1);
        send_word(i2cm_pkg::CMD_NONE, 8'h00, 7'h00, 1'b0, 1'b0);
        wait_results();

        // Random phases; a zero half period must behave like one tick, and the
        // middle phase runs with no gaps on either side.
        phase_setting[0] = 16'd2;
        phase_setting[1] = 16'd0;
        phase_setting[2] = 16'd1;
        phase_setting[3] = 16'd3;
        phase_setting[4] = 16'($urandom_range(1, 6));
        for (int p = 0; p < 5; p++) begin
            write_half_period(phase_setting[p]);
            gaps_on = (p != 2);
            random_ticks(PHASE_WORDS);
            run_until_idle(1'($urandom));
        end
        gaps_on = 1'b1;

        // The longest phase: a command starts and the run ends while it is underway.
        write_half_period(16'hFFFF);
        random_ticks(150);
        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d tick words over %0d half-period settings, zero and 65535 included.",
                 words_sent, settings_used);
        $display("%0d commands completed; each result word was compared field by field.",
                 done_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_seq.sv
rtl/i2c_master_byte_engine.sv
tb/i2cm_bus_checker.sv
tb/tb_i2c_master_byte_engine.sv
